// ----- sv/ffca_pkg.sv -----
package ffca_pkg;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 27;
    localparam int MAXR_W = 11;
    localparam int DATA_W = 64;
    localparam int PADDR_W = 4;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        REG_POOL_BASE   = 1'b0,
        REG_MAX_REGIONS = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        K_FREE,
        K_BIG,
        K_HIT,
        K_MISS
    } t_kind;

    typedef struct packed {
        t_action                action;
        logic [SIZE_W-1:0]      request_size;
        logic [ADDR_W-1:0]      chunk_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]      result_address;
        logic [SIZE_W-1:0]      granted_size;
        t_status                status;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0]      addr;
        logic [SIZE_W-1:0]      size;
    } t_free_entry;

    localparam logic [MAXR_W-1:0] MAXR_RESET = MAXR_W'(16);

endpackage

// ----- sv/first_fit_chunk_allocator_core.sv -----
// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------
// request  | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
// result   | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
// config   | psel/penable | pready (=1)  | paddr, pwdata, prdata
//
// A free, or an allocate larger than a region, goes straight to the final step. An
// allocate scans the free list from the head (one free-list memory read per cycle);
// on a hit past position 0 it then moves the entries ahead of the hit back one slot.
// A miss scans the whole list.
// Reset is synchronous; the free list needs no clearing pass.
// A held result stalls only the final step of the next item.
module first_fit_chunk_allocator_core
    import ffca_pkg::*;
#(
    parameter int FREE_SLOTS   = 64,
    parameter int REGION_BYTES = 67108864,
    parameter int HEADER_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int IW = $clog2(FREE_SLOTS);
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam int EW = $bits(t_free_entry);
    localparam logic [SIZE_W-1:0] REGION_SZ = SIZE_W'(REGION_BYTES);
    localparam logic [SIZE_W:0]   HDR_SZ    = (SIZE_W + 1)'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] HDR_AD    = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] STRIDE    = ADDR_W'(HEADER_BYTES + REGION_BYTES);
    localparam logic [CW-1:0]     SLOTS_C   = CW'(FREE_SLOTS);

    function automatic logic [IW-1:0] f_phys(input logic [IW-1:0] head,
                                             input logic [CW-1:0] j);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(j);
        if (s >= (CW + 1)'(FREE_SLOTS)) begin
            s = s - (CW + 1)'(FREE_SLOTS);
        end
        return s[IW-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_pool_base;
    logic [MAXR_W-1:0]   r_max_regions;
    logic [IW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [MAXR_W-1:0]   r_regions, n_regions;
    logic [ADDR_W-1:0]   r_region_off, n_region_off;
    t_in_item            r_item, n_item;
    t_kind               r_kind, n_kind;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_cmp_v, n_cmp_v;
    logic [CW-1:0]       r_cmp_idx, n_cmp_idx;
    t_free_entry         r_hit, n_hit;
    logic [CW-1:0]       r_sh_idx, n_sh_idx;
    logic                r_sh_more, n_sh_more;
    logic                r_sh_pend, n_sh_pend;
    logic [CW-1:0]       r_sh_wr, n_sh_wr;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_data, n_out_data;

    logic                w_we;
    logic [IW-1:0]       w_waddr;
    t_free_entry         w_wdata;
    logic [IW-1:0]       w_raddr;
    logic [EW-1:0]       w_rdata;
    t_free_entry         w_rd_e;

    t_free_entry         w_base;
    t_free_entry         w_rem;
    logic [SIZE_W:0]     w_need;
    logic                w_split;
    logic                w_full;
    logic                w_exhaust;
    logic [IW-1:0]       w_head_dec;
    logic [IW-1:0]       w_head_inc;
    logic                w_cfg_we;

    ffca_ram #(
        .WIDTH (EW),
        .DEPTH (FREE_SLOTS)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_e = w_rdata;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[3] == REG_POOL_BASE) begin
            prdata = DATA_W'(r_pool_base);
        end else begin
            prdata = DATA_W'(r_max_regions);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_max_regions <= MAXR_RESET;
        end else if (w_cfg_we) begin
            if (paddr[3] == REG_POOL_BASE) begin
                r_pool_base <= pwdata[ADDR_W-1:0];
            end else begin
                r_max_regions <= pwdata[MAXR_W-1:0];
            end
        end
    end

    // chunk arithmetic for the final step
    always_comb begin
        if (r_kind == K_HIT) begin
            w_base = r_hit;
        end else begin
            w_base.addr = r_pool_base + r_region_off;
            w_base.size = REGION_SZ;
        end
        w_need     = (SIZE_W + 1)'(r_item.request_size) + HDR_SZ;
        w_split    = w_need < (SIZE_W + 1)'(w_base.size);
        w_rem.addr = w_base.addr + HDR_AD + ADDR_W'(r_item.request_size);
        w_rem.size = w_base.size - r_item.request_size - HDR_SZ[SIZE_W-1:0];
        w_full     = r_count >= SLOTS_C;
        w_exhaust  = r_regions >= r_max_regions;
        w_head_dec = (r_head == '0) ? IW'(FREE_SLOTS - 1) : r_head - 1'b1;
        w_head_inc = (r_head == IW'(FREE_SLOTS - 1)) ? '0 : r_head + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_regions    <= '0;
            r_region_off <= '0;
            r_cmp_v      <= 1'b0;
            r_sh_more    <= 1'b0;
            r_sh_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_regions    <= n_regions;
            r_region_off <= n_region_off;
            r_cmp_v      <= n_cmp_v;
            r_sh_more    <= n_sh_more;
            r_sh_pend    <= n_sh_pend;
            r_out_valid  <= n_out_valid;
        end
        r_item     <= n_item;
        r_kind     <= n_kind;
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_sh_idx   <= n_sh_idx;
        r_sh_wr    <= n_sh_wr;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_regions    = r_regions;
        n_region_off = r_region_off;
        n_item       = r_item;
        n_kind       = r_kind;
        n_rd_idx     = r_rd_idx;
        n_cmp_v      = r_cmp_v;
        n_cmp_idx    = r_cmp_idx;
        n_hit        = r_hit;
        n_sh_idx     = r_sh_idx;
        n_sh_more    = r_sh_more;
        n_sh_pend    = r_sh_pend;
        n_sh_wr      = r_sh_wr;
        n_out_data   = r_out_data;
        n_out_valid  = r_out_valid && i_out_stall;
        w_we         = 1'b0;
        w_waddr      = r_head;
        w_wdata      = w_rd_e;
        w_raddr      = f_phys(r_head, r_rd_idx);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in_data;
                    n_rd_idx = '0;
                    n_cmp_v  = 1'b0;
                    if (i_in_data.action == ACT_FREE) begin
                        n_kind  = K_FREE;
                        n_state = S_DONE;
                    end else if (i_in_data.request_size > REGION_SZ) begin
                        n_kind  = K_BIG;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cmp_v && (w_rd_e.size >= r_item.request_size)) begin
                    n_hit   = w_rd_e;
                    n_cmp_v = 1'b0;
                    n_kind  = K_HIT;
                    if (r_cmp_idx == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state   = S_SHIFT;
                        n_sh_idx  = r_cmp_idx - 1'b1;
                        n_sh_more = 1'b1;
                        n_sh_pend = 1'b0;
                    end
                end else if (r_rd_idx < r_count) begin
                    w_raddr   = f_phys(r_head, r_rd_idx);
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_rd_idx;
                    n_rd_idx  = r_rd_idx + 1'b1;
                end else begin
                    n_cmp_v = 1'b0;
                    n_kind  = K_MISS;
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (r_sh_pend) begin
                    w_we    = 1'b1;
                    w_waddr = f_phys(r_head, r_sh_wr);
                    w_wdata = w_rd_e;
                end
                if (r_sh_more) begin
                    w_raddr   = f_phys(r_head, r_sh_idx);
                    n_sh_pend = 1'b1;
                    n_sh_wr   = r_sh_idx + 1'b1;
                    if (r_sh_idx == '0) begin
                        n_sh_more = 1'b0;
                    end else begin
                        n_sh_idx = r_sh_idx - 1'b1;
                    end
                end else begin
                    n_sh_pend = 1'b0;
                    if (!r_sh_pend) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_out_data  = '{result_address: '0, granted_size: '0, status: ST_OK};
                    case (r_kind)
                        K_FREE: begin
                            n_out_data.result_address = r_item.chunk_address;
                            n_out_data.granted_size   = r_item.request_size;
                            if (w_full) begin
                                n_out_data.status = ST_FULL;
                            end else begin
                                w_we         = 1'b1;
                                w_waddr      = w_head_dec;
                                w_wdata.addr = r_item.chunk_address;
                                w_wdata.size = r_item.request_size;
                                n_head       = w_head_dec;
                                n_count      = r_count + 1'b1;
                            end
                        end
                        K_BIG: begin
                            n_out_data.status = ST_TOO_LARGE;
                        end
                        K_HIT: begin
                            n_out_data.result_address = w_base.addr;
                            if (w_split) begin
                                n_out_data.granted_size = r_item.request_size;
                                w_we    = 1'b1;
                                w_waddr = r_head;
                                w_wdata = w_rem;
                            end else begin
                                n_out_data.granted_size = w_base.size;
                                n_head  = w_head_inc;
                                n_count = r_count - 1'b1;
                            end
                        end
                        K_MISS: begin
                            if (w_exhaust) begin
                                n_out_data.status = ST_EXHAUSTED;
                            end else if (w_split && w_full) begin
                                n_out_data.status = ST_FULL;
                            end else begin
                                n_out_data.result_address = w_base.addr;
                                n_regions    = r_regions + 1'b1;
                                n_region_off = r_region_off + STRIDE;
                                if (w_split) begin
                                    n_out_data.granted_size = r_item.request_size;
                                    w_we    = 1'b1;
                                    w_waddr = w_head_dec;
                                    w_wdata = w_rem;
                                    n_head  = w_head_dec;
                                    n_count = r_count + 1'b1;
                                end else begin
                                    n_out_data.granted_size = REGION_SZ;
                                end
                            end
                        end
                        default: begin
                            n_out_data.status = ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("free list count above capacity");

    a_regions_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_regions != $past(r_regions)) |-> (r_regions == $past(r_regions) + 1'b1))
        else $error("region count moved by more than one");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_SHIFT || r_state == S_DONE))
        else $error("free list written outside shift or final step");

    a_too_large_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.status == ST_TOO_LARGE)
            |-> (r_out_data.result_address == '0 && r_out_data.granted_size == '0))
        else $error("too large result carries a chunk");

endmodule

// ----- sv/ffca_ram.sv -----
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- test/first_fit_chunk_allocator_checker.sv -----
`timescale 1ns / 1ps

module first_fit_chunk_allocator_checker
    import ffca_pkg::*;
#(
    parameter int FREE_SLOTS   = 64,
    parameter int REGION_BYTES = 67108864,
    parameter int HEADER_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_item           i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_item          i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0]  i_pwdata,
    output int                 o_fail_count,
    output int                 o_open_results
);

    logic [ADDR_W-1:0] chunk_addr [FREE_SLOTS];
    logic [SIZE_W-1:0] chunk_size [FREE_SLOTS];
    int                chunk_count;
    int                carved_regions;
    logic [ADDR_W-1:0] pool_base;
    logic [MAXR_W-1:0] max_regions;
    t_out_item         pending_grants [$];

    task automatic push_head(input logic [ADDR_W-1:0] a, input logic [SIZE_W-1:0] s);
        int i;
        for (i = chunk_count; i > 0; i--) begin
            chunk_addr[i] = chunk_addr[i-1];
            chunk_size[i] = chunk_size[i-1];
        end
        chunk_addr[0] = a;
        chunk_size[0] = s;
        chunk_count++;
    endtask

    task automatic predict_grant(input t_in_item it, output t_out_item res);
        logic [63:0] want;
        logic [63:0] base;
        logic [63:0] span;
        int          hit;
        int          i;
        bit          fit;
        want = 64'(it.request_size);
        base = '0;
        span = '0;
        hit  = 0;
        fit  = 1'b0;
        res.result_address = '0;
        res.granted_size   = '0;
        res.status         = ST_OK;
        if (it.action == ACT_FREE) begin
            res.result_address = it.chunk_address;
            res.granted_size   = it.request_size;
            if (chunk_count >= FREE_SLOTS) begin
                res.status = ST_FULL;
            end else begin
                push_head(it.chunk_address, it.request_size);
            end
        end else if (want > 64'(REGION_BYTES)) begin
            res.status = ST_TOO_LARGE;
        end else begin
            for (i = 0; i < chunk_count && !fit; i++) begin
                if (64'(chunk_size[i]) >= want) begin
                    base = 64'(chunk_addr[i]);
                    span = 64'(chunk_size[i]);
                    hit  = i;
                    fit  = 1'b1;
                end
            end
            if (fit) begin
                for (i = hit; i + 1 < chunk_count; i++) begin
                    chunk_addr[i] = chunk_addr[i+1];
                    chunk_size[i] = chunk_size[i+1];
                end
                chunk_count--;
            end else if (carved_regions >= int'(max_regions)) begin
                res.status = ST_EXHAUSTED;
            end else if (want + 64'(HEADER_BYTES) < 64'(REGION_BYTES)
                         && chunk_count >= FREE_SLOTS) begin
                res.status = ST_FULL;
            end else begin
                base = 64'(pool_base)
                     + 64'(carved_regions) * 64'(HEADER_BYTES + REGION_BYTES);
                span = 64'(REGION_BYTES);
                carved_regions++;
                fit = 1'b1;
            end
            if (fit) begin
                res.result_address = ADDR_W'(base);
                if (want + 64'(HEADER_BYTES) < span) begin
                    push_head(ADDR_W'(base + 64'(HEADER_BYTES) + want),
                              SIZE_W'(span - want - 64'(HEADER_BYTES)));
                    res.granted_size = SIZE_W'(want);
                end else begin
                    res.granted_size = SIZE_W'(span);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item predicted;
        t_out_item oldest;
        if (!i_rst_n) begin
            chunk_count    = 0;
            carved_regions = 0;
            pool_base      = '0;
            max_regions    = MAXR_RESET;
            o_fail_count   = 0;
            pending_grants.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3]))
                    REG_POOL_BASE:   pool_base   = i_pwdata[ADDR_W-1:0];
                    REG_MAX_REGIONS: max_regions = i_pwdata[MAXR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_grant(i_in_data, predicted);
                pending_grants.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_grants.size() == 0) begin
                    $error("result transfer with nothing expected: %h", i_out_data);
                    o_fail_count++;
                end else begin
                    oldest = pending_grants.pop_front();
                    if (i_out_data.result_address !== oldest.result_address) begin
                        $error("result_address: expected %h, got %h",
                               oldest.result_address, i_out_data.result_address);
                        o_fail_count++;
                    end
                    if (i_out_data.granted_size !== oldest.granted_size) begin
                        $error("granted_size: expected %h, got %h",
                               oldest.granted_size, i_out_data.granted_size);
                        o_fail_count++;
                    end
                    if (i_out_data.status !== oldest.status) begin
                        $error("status: expected %0d, got %0d",
                               oldest.status, i_out_data.status);
                        o_fail_count++;
                    end
                end
            end
        end
        o_open_results = pending_grants.size();
    end

endmodule

// ----- test/first_fit_chunk_allocator_core_test.sv -----
`timescale 1ns / 1ps

module first_fit_chunk_allocator_core_test;
    import ffca_pkg::*;

    localparam int FREE_SLOTS   = 64;
    localparam int REGION_BYTES = 67108864;
    localparam int HEADER_BYTES = 16;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_CYCLES = 100;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_item           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int          fail_count;
    int          open_results;
    int          tx_count    = 0;
    int          rx_count    = 0;
    int          holds_asked = 0;
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;
    t_action     sent_actions [$];
    t_free_entry live_chunks [$];

    always #2 clk = ~clk;

    first_fit_chunk_allocator_core #(
        .FREE_SLOTS   (FREE_SLOTS),
        .REGION_BYTES (REGION_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    first_fit_chunk_allocator_checker #(
        .FREE_SLOTS   (FREE_SLOTS),
        .REGION_BYTES (REGION_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_open_results (open_results)
    );

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: count transfers, record live grants, stall in bursts
    initial begin
        int      burst;
        int      holds_done;
        t_action act;
        burst      = 0;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                rx_count <= rx_count + 1;
                if (sent_actions.size() > 0) begin
                    act = sent_actions.pop_front();
                    if (act == ACT_ALLOC && out_data.status == ST_OK) begin
                        live_chunks.push_back('{addr: out_data.result_address,
                                                size: out_data.granted_size});
                    end
                end
            end
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                burst      = LONG_HOLD;
            end
            if (burst > 0) begin
                out_stall <= 1'b1;
                burst--;
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                burst = $urandom_range(0, 5);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in_item make_request(t_action act, int unsigned sz,
                                              logic [ADDR_W-1:0] addr);
        t_in_item it;
        it.action        = act;
        it.request_size  = SIZE_W'(sz);
        it.chunk_address = addr;
        return it;
    endfunction

    function automatic t_in_item random_request();
        t_in_item it;
        int       pick;
        int       k;
        it   = make_request(ACT_ALLOC, $urandom_range(0, 4096),
                            ADDR_W'({$urandom(), $urandom()}));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            it.action = ACT_FREE;
            if (live_chunks.size() > 0) begin
                k = $urandom_range(0, live_chunks.size() - 1);
                it.chunk_address = live_chunks[k].addr;
                it.request_size  = live_chunks[k].size;
                live_chunks.delete(k);
            end
        end else if (pick < 40) begin
            it.action       = ACT_FREE;
            it.request_size = SIZE_W'($urandom());
        end else if (pick < 50) begin
            it.request_size = SIZE_W'($urandom());
        end else if (pick < 56) begin
            it.request_size = SIZE_W'(REGION_BYTES - $urandom_range(0, 48));
        end else if (pick < 62) begin
            it.request_size = SIZE_W'($urandom_range(0, 1 << 20));
        end
        return it;
    endfunction

    task automatic send_request(input t_in_item it);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_actions.push_back(it.action);
        tx_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (rx_count != tx_count) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // fill the list with tiny chunks, use up the big ones, then miss with a split
    task automatic pack_list();
        repeat (70) begin
            send_request(make_request(ACT_FREE, $urandom_range(0, 15),
                                      ADDR_W'({$urandom(), $urandom()})));
        end
        repeat (8) send_request(make_request(ACT_ALLOC, REGION_BYTES, '0));
        repeat (4) begin
            send_request(make_request(ACT_ALLOC,
                                      REGION_BYTES - 32 - $urandom_range(0, 255), '0));
        end
    endtask

    initial begin
        logic [DATA_W-1:0] pool_list [6];
        logic [DATA_W-1:0] maxr_list [6];
        logic [ADDR_W-1:0] all_ones;
        int                p;
        all_ones     = '1;
        pool_list[0] = 64'(ADDR_W'({$urandom(), $urandom()}));
        pool_list[1] = '0;
        pool_list[2] = 64'(all_ones);
        pool_list[3] = 64'(ADDR_W'({$urandom(), $urandom()}));
        pool_list[4] = 64'(ADDR_W'({$urandom(), $urandom()}));
        pool_list[5] = 64'(ADDR_W'({$urandom(), $urandom()}));
        maxr_list[0] = 64'd1024;
        maxr_list[1] = 64'($urandom_range(0, 1024));
        maxr_list[2] = 64'd1;
        maxr_list[3] = 64'($urandom_range(0, 1024));
        maxr_list[4] = 64'd1024;
        maxr_list[5] = 64'd1024;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(ACT_ALLOC, 0, '0));
        send_request(make_request(ACT_ALLOC, 100, '0));
        send_request(make_request(ACT_ALLOC, REGION_BYTES, '0));
        send_request(make_request(ACT_ALLOC, REGION_BYTES + 1, '0));
        send_request(make_request(ACT_ALLOC, (1 << SIZE_W) - 1, all_ones));
        send_request(make_request(ACT_ALLOC, REGION_BYTES - HEADER_BYTES, '0));
        send_request(make_request(ACT_ALLOC, REGION_BYTES - HEADER_BYTES - 1, '0));
        send_request(make_request(ACT_FREE, (1 << SIZE_W) - 1, all_ones));
        send_request(make_request(ACT_FREE, 0, '0));
        send_request(make_request(ACT_ALLOC, 1, '0));
        send_request(make_request(ACT_ALLOC, 0, '0));
        send_request(make_request(ACT_FREE, 27'h2AA_AAAA, 48'hAAAA_AAAA_AAAA));
        send_request(make_request(ACT_FREE, 27'h555_5555, 48'h5555_5555_5555));
        drain();
        write_reg(REG_MAX_REGIONS, '0);
        write_reg(REG_POOL_BASE, 64'(all_ones));
        repeat (3) send_request(make_request(ACT_ALLOC, REGION_BYTES, '0));
        send_request(make_request(ACT_ALLOC, REGION_BYTES - HEADER_BYTES - 1, '0));
        drain();
        write_reg(REG_MAX_REGIONS, 64'd1024);
        send_request(make_request(ACT_ALLOC, REGION_BYTES, '0));
        send_request(make_request(ACT_FREE, REGION_BYTES, '0));
        send_request(make_request(ACT_ALLOC, REGION_BYTES, '0));

        for (p = 0; p < 6; p++) begin
            drain();
            write_reg(REG_POOL_BASE, pool_list[p]);
            write_reg(REG_MAX_REGIONS, maxr_list[p]);
            tx_idle_en <= (p != 3 && p != 5);
            rx_idle_en <= (p != 3 && p != 5);
            if (p == 1) holds_asked <= holds_asked + 1;
            if (p % 2 == 0) pack_list();
            repeat (p % 2 == 0 ? 70 : 150) send_request(random_request());
        end

        drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        if (fail_count == 0 && open_results == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
